// ----- hdl/grid_greedy_best_first_step_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the grid greedy best-first step unit
// Concurrent checks on clock, disabled while reset is high; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef GRID_GREEDY_BEST_FIRST_STEP_UNIT_DEFINES_SVH
`define GRID_GREEDY_BEST_FIRST_STEP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// hold cond at every edge
`define GGBF_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// cons in the cycle after ante
`define GGBF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GGBF_ASSERT(lbl, cond, msg)
`define GGBF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/ggbf_pkg.sv -----
// ----------------------------------------------------------------------------
// ggbf_pkg
// Shared types and codes of the grid greedy best-first step unit.
// ----------------------------------------------------------------------------
package ggbf_pkg;

   // request kinds carried in req_tuser
   localparam logic REQ_MAP_WRITE = 1'b0;
   localparam logic REQ_QUERY     = 1'b1;

   // neighbor order
   localparam logic [1:0] NB_ROW_INC = 2'd0;
   localparam logic [1:0] NB_ROW_DEC = 2'd1;
   localparam logic [1:0] NB_COL_INC = 2'd2;
   localparam logic [1:0] NB_COL_DEC = 2'd3;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CLR,
      S_MARK,
      S_NREAD,
      S_NCHK,
      S_SHIFT,
      S_PLACE,
      S_POP,
      S_POPD,
      S_EMIT
   } state_type;

endpackage

// ----- hdl/ggbf_ram.sv -----
// ----------------------------------------------------------------------------
// ggbf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ggbf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hdl/grid_greedy_best_first_step_unit.sv -----
// ----------------------------------------------------------------------------
// Steps: a map write is taken in S_IDLE with no response. A query is taken there, S_CLR
//   clears the closed map, then per expanded cell S_MARK closes it, each neighbor is read
//   in S_NREAD and, if inside the grid, checked in S_NCHK; a push into a nonempty store
//   shifts in S_SHIFT (S_PLACE at the bottom); S_POP, S_POPD pop; S_POP may find the store
//   empty; S_EMIT waits while the response register is busy. One request at a time; the
//   search walk sets the rate. Reset: S_INIT sets every map cell to wall, taking no request.
// ----------------------------------------------------------------------------
`include "grid_greedy_best_first_step_unit_defines.svh"

// ----------------------------------------------------------------------------
// grid_greedy_best_first_step_unit
// Greedy best-first search on a wall map held in RAM, keyed on Manhattan
// distance to the goal; answers with the first move of the found path.
// ----------------------------------------------------------------------------
module grid_greedy_best_first_step_unit
   import ggbf_pkg::*;
#(
   parameter int GRID_SIDE  = 32,
   parameter int OPEN_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cell_col[4:0] cell_row[9:5] cell_open[10] start_col[15:11]
   // start_row[20:16] goal_col[25:21] goal_row[30:26] zero[31]
   input  logic [31:0] req_tdata,
   // req_type[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_col[4:0] next_row[9:5] goal_reached[10] overflowed[11] zero[15:12]
   output logic [15:0] rsp_tdata
);

   // grid geometry
   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int CA    = $clog2(CELLS);          // cell address bits
   localparam int CW    = $clog2(GRID_SIDE);      // stored coordinate bits
   localparam int AW    = (CW > 5) ? CW : 5;      // working coordinate bits
   localparam int DW    = AW + 1;                 // distance bits
   // open store entry: {dist, col, row, first col, first row}
   localparam int EW    = DW + 4 * CW;
   localparam int OW    = $clog2(OPEN_DEPTH);
   localparam int CNTW  = $clog2(OPEN_DEPTH + 1);

   state_type        state_ff, state_in;
   logic [1:0]       k_ff, k_in;
   logic [CA-1:0]    clr_ff, clr_in;
   logic [AW-1:0]    cur_col_ff, cur_col_in, cur_row_ff, cur_row_in;
   logic [AW-1:0]    fst_col_ff, fst_col_in, fst_row_ff, fst_row_in;
   logic [AW-1:0]    last_col_ff, last_col_in, last_row_ff, last_row_in;
   logic [4:0]       goal_col_ff, goal_col_in, goal_row_ff, goal_row_in;
   logic             from_start_ff, from_start_in;
   logic             ovf_ff, ovf_in;
   logic             reached_ff, reached_in;
   logic [CNTW-1:0]  ocnt_ff, ocnt_in;
   logic [OW-1:0]    idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff, rsp_data_in;

   // request fields
   logic [4:0] f_cell_col, f_cell_row, f_start_col, f_start_row, f_goal_col, f_goal_row;
   logic       f_cell_open;
   assign f_cell_col  = req_tdata[4:0];
   assign f_cell_row  = req_tdata[9:5];
   assign f_cell_open = req_tdata[10];
   assign f_start_col = req_tdata[15:11];
   assign f_start_row = req_tdata[20:16];
   assign f_goal_col  = req_tdata[25:21];
   assign f_goal_row  = req_tdata[30:26];

   // memory ports
   logic          wall_we, wall_wd, wall_rd;
   logic [CA-1:0] wall_wa;
   logic          clo_we, clo_wd, clo_rd;
   logic [CA-1:0] clo_wa;
   logic          open_we;
   logic [OW-1:0] open_wa, open_ra;
   logic [EW-1:0] open_wd, open_rd;

   // write-cell decode
   logic [AW-1:0] w_col, w_row;
   logic          w_inside;
   logic [CA-1:0] w_addr;
   assign w_col    = AW'(f_cell_col);
   assign w_row    = AW'(f_cell_row);
   assign w_inside = ({1'b0, w_col} < (AW+1)'(GRID_SIDE))
                  && ({1'b0, w_row} < (AW+1)'(GRID_SIDE));
   assign w_addr   = CA'(w_row[CW-1:0]) * CA'(GRID_SIDE) + CA'(w_col[CW-1:0]);

   // current cell
   logic          cur_inside;
   logic [CA-1:0] cur_addr;
   assign cur_inside = ({1'b0, cur_col_ff} < (AW+1)'(GRID_SIDE))
                    && ({1'b0, cur_row_ff} < (AW+1)'(GRID_SIDE));
   assign cur_addr   = CA'(cur_row_ff[CW-1:0]) * CA'(GRID_SIDE) + CA'(cur_col_ff[CW-1:0]);

   // neighbor k of the current cell; below zero wraps to all ones, hence outside
   logic [AW:0]   nb_col, nb_row;
   logic          nb_inside;
   logic [CW-1:0] nb_cc, nb_rc;
   logic [CA-1:0] nb_addr;
   logic [AW-1:0] nb_ca, nb_ra, g_ca, g_ra, dx, dy;
   logic [DW-1:0] nb_dist;
   logic [EW-1:0] new_entry;

   always_comb begin
      nb_col = {1'b0, cur_col_ff};
      nb_row = {1'b0, cur_row_ff};
      case (k_ff)
         NB_ROW_INC: nb_row = {1'b0, cur_row_ff} + (AW+1)'(1);
         NB_ROW_DEC: nb_row = {1'b0, cur_row_ff} - (AW+1)'(1);
         NB_COL_INC: nb_col = {1'b0, cur_col_ff} + (AW+1)'(1);
         default:    nb_col = {1'b0, cur_col_ff} - (AW+1)'(1);
      endcase
   end

   assign nb_inside = (nb_col < (AW+1)'(GRID_SIDE)) && (nb_row < (AW+1)'(GRID_SIDE));
   assign nb_cc     = nb_col[CW-1:0];
   assign nb_rc     = nb_row[CW-1:0];
   assign nb_addr   = CA'(nb_rc) * CA'(GRID_SIDE) + CA'(nb_cc);
   assign nb_ca     = AW'(nb_cc);
   assign nb_ra     = AW'(nb_rc);
   assign g_ca      = AW'(goal_col_ff);
   assign g_ra      = AW'(goal_row_ff);
   assign dx        = (nb_ca > g_ca) ? (nb_ca - g_ca) : (g_ca - nb_ca);
   assign dy        = (nb_ra > g_ra) ? (nb_ra - g_ra) : (g_ra - nb_ra);
   // key order equals distance order, so distance stands in for the key
   assign nb_dist   = DW'(dx) + DW'(dy);
   assign new_entry = {nb_dist, nb_cc, nb_rc,
                       from_start_ff ? nb_cc : fst_col_ff[CW-1:0],
                       from_start_ff ? nb_rc : fst_row_ff[CW-1:0]};

   // fields of the open entry read back
   logic [DW-1:0] e_dist;
   logic [CW-1:0] e_col, e_row, e_fcol, e_frow;
   assign e_dist = open_rd[EW-1 -: DW];
   assign e_col  = open_rd[4*CW-1 -: CW];
   assign e_row  = open_rd[3*CW-1 -: CW];
   assign e_fcol = open_rd[2*CW-1 -: CW];
   assign e_frow = open_rd[CW-1:0];

   logic pop_hit;
   assign pop_hit = (AW'(e_col) == g_ca) && (AW'(e_row) == g_ra);

   logic [CNTW-1:0] ocnt_dec;
   assign ocnt_dec = ocnt_ff - CNTW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ocnt_ff      <= '0;
         last_col_ff  <= '0;
         last_row_ff  <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         ocnt_ff      <= ocnt_in;
         last_col_ff  <= last_col_in;
         last_row_ff  <= last_row_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      cur_col_ff    <= cur_col_in;
      cur_row_ff    <= cur_row_in;
      fst_col_ff    <= fst_col_in;
      fst_row_ff    <= fst_row_in;
      goal_col_ff   <= goal_col_in;
      goal_row_ff   <= goal_row_in;
      from_start_ff <= from_start_in;
      reached_ff    <= reached_in;
      idx_ff        <= idx_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      clr_in        = clr_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      fst_col_in    = fst_col_ff;
      fst_row_in    = fst_row_ff;
      last_col_in   = last_col_ff;
      last_row_in   = last_row_ff;
      goal_col_in   = goal_col_ff;
      goal_row_in   = goal_row_ff;
      from_start_in = from_start_ff;
      ovf_in        = ovf_ff;
      reached_in    = reached_ff;
      ocnt_in       = ocnt_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      req_tready    = 1'b0;

      wall_we = 1'b0;
      wall_wa = w_addr;
      wall_wd = f_cell_open;
      clo_we  = 1'b0;
      clo_wa  = cur_addr;
      clo_wd  = 1'b1;
      open_we = 1'b0;
      open_wa = idx_ff + OW'(1);
      open_wd = open_rd;
      open_ra = idx_ff;

      case (state_ff)
         S_INIT: begin
            // sweep the wall map to all walls
            wall_we = 1'b1;
            wall_wa = clr_ff;
            wall_wd = 1'b0;
            clr_in  = clr_ff + CA'(1);
            if (clr_ff == CA'(CELLS - 1)) begin
               clr_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser[0] == REQ_MAP_WRITE) begin
                  wall_we = w_inside;
               end else begin
                  cur_col_in    = AW'(f_start_col);
                  cur_row_in    = AW'(f_start_row);
                  fst_col_in    = AW'(f_start_col);
                  fst_row_in    = AW'(f_start_row);
                  last_col_in   = AW'(f_start_col);
                  last_row_in   = AW'(f_start_row);
                  goal_col_in   = f_goal_col;
                  goal_row_in   = f_goal_row;
                  from_start_in = 1'b1;
                  ovf_in        = 1'b0;
                  reached_in    = 1'b0;
                  ocnt_in       = '0;
                  clr_in        = '0;
                  state_in      = S_CLR;
               end
            end
         end
         S_CLR: begin
            // clear the closed map for this query
            clo_we = 1'b1;
            clo_wa = clr_ff;
            clo_wd = 1'b0;
            clr_in = clr_ff + CA'(1);
            if (clr_ff == CA'(CELLS - 1)) begin
               clr_in   = '0;
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            // close the current cell; a start outside the grid stays open
            clo_we   = cur_inside;
            k_in     = NB_ROW_INC;
            state_in = S_NREAD;
         end
         S_NREAD: begin
            // map reads of nb_addr are issued every cycle; advance past outside cells
            if (nb_inside) begin
               state_in = S_NCHK;
            end else if (k_ff == NB_COL_DEC) begin
               state_in = S_POP;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_NCHK: begin
            if (wall_rd && !clo_rd && (ocnt_ff == CNTW'(OPEN_DEPTH))) begin
               // store full: drop the push
               ovf_in = 1'b1;
            end
            if (wall_rd && !clo_rd && (ocnt_ff != CNTW'(OPEN_DEPTH))) begin
               if (ocnt_ff == '0) begin
                  open_we = 1'b1;
                  open_wa = '0;
                  open_wd = new_entry;
                  ocnt_in = CNTW'(1);
               end else begin
                  open_ra  = ocnt_dec[OW-1:0];
                  idx_in   = ocnt_dec[OW-1:0];
                  state_in = S_SHIFT;
               end
            end
            if (!(wall_rd && !clo_rd && (ocnt_ff != CNTW'(OPEN_DEPTH))) ||
                (ocnt_ff == '0)) begin
               if (k_ff == NB_COL_DEC) begin
                  state_in = S_POP;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_NREAD;
               end
            end
         end
         S_SHIFT: begin
            // walk down from the top, moving entries with key <= new key up by one
            open_we = 1'b1;
            if (e_dist <= nb_dist) begin
               open_wd = open_rd;
               if (idx_ff == '0) begin
                  state_in = S_PLACE;
               end else begin
                  open_ra = idx_ff - OW'(1);
                  idx_in  = idx_ff - OW'(1);
               end
            end else begin
               open_wd = new_entry;
               ocnt_in = ocnt_ff + CNTW'(1);
               if (k_ff == NB_COL_DEC) begin
                  state_in = S_POP;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_NREAD;
               end
            end
         end
         S_PLACE: begin
            open_we = 1'b1;
            open_wa = '0;
            open_wd = new_entry;
            ocnt_in = ocnt_ff + CNTW'(1);
            if (k_ff == NB_COL_DEC) begin
               state_in = S_POP;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_NREAD;
            end
         end
         S_POP: begin
            if (ocnt_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               open_ra  = ocnt_dec[OW-1:0];
               ocnt_in  = ocnt_dec;
               state_in = S_POPD;
            end
         end
         S_POPD: begin
            last_col_in   = AW'(e_fcol);
            last_row_in   = AW'(e_frow);
            cur_col_in    = AW'(e_col);
            cur_row_in    = AW'(e_row);
            fst_col_in    = AW'(e_fcol);
            fst_row_in    = AW'(e_frow);
            from_start_in = 1'b0;
            if (pop_hit) begin
               reached_in = 1'b1;
               state_in   = S_EMIT;
            end else begin
               state_in = S_MARK;
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, ovf_ff, reached_ff, last_row_ff[4:0], last_col_ff[4:0]};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   ggbf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_ram (
      .clock   (clock),
      .wr_en   (wall_we),
      .wr_addr (wall_wa),
      .wr_data (wall_wd),
      .rd_addr (nb_addr),
      .rd_data (wall_rd)
   );

   ggbf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_closed_ram (
      .clock   (clock),
      .wr_en   (clo_we),
      .wr_addr (clo_wa),
      .wr_data (clo_wd),
      .rd_addr (nb_addr),
      .rd_data (clo_rd)
   );

   ggbf_ram #(.WIDTH(EW), .DEPTH(OPEN_DEPTH)) u_open_ram (
      .clock   (clock),
      .wr_en   (open_we),
      .wr_addr (open_wa),
      .wr_data (open_wd),
      .rd_addr (open_ra),
      .rd_data (open_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `GGBF_ASSERT(a_count_bound, ocnt_ff <= CNTW'(OPEN_DEPTH), "open count above depth")
   `GGBF_ASSERT(a_shift_index, (state_ff != S_SHIFT) || (CNTW'(idx_ff) < ocnt_ff), "shift index")
   `GGBF_ASSERT_NEXT(a_goal_emit, (state_ff == S_POPD) && pop_hit, state_ff == S_EMIT, "no emit")

endmodule
